@@ rtl/cir_pkg.sv @@
`timescale 1ns / 1ps
package cir_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   // Width of a full signed product plus one guard bit.
   localparam int PW = 2 * W + 1;
   // Inverse-mass sum width.
   localparam int DW = W + 1;
   // Quotient bits of the impulse scalar before saturation.
   localparam int QB = W - 1;
   // Divider remainder width.
   localparam int RW = DW + QB;
   localparam int BW = 17;
   localparam int FCW = ((F > BW) ? F : BW) + 1;
   localparam int PRW = FCW + DW;

   localparam logic signed [PW-1:0] SAT_MAX = $signed({{(PW-W+1){1'b0}}, {(W-1){1'b1}}});
   localparam logic signed [PW-1:0] SAT_MIN = $signed({{(PW-W+1){1'b1}}, {(W-1){1'b0}}});
   localparam logic [PW-1:0] TRUNC_BIAS = (PW'(1) << F) - PW'(1);
   localparam logic [W-1:0] ONE_Q = W'(1) << F;
   localparam logic [W-1:0] NEG_ONE_Q = W'(~ONE_Q + W'(1));
   localparam logic [W-2:0] WMAX_MAG = {(W-1){1'b1}};

   typedef struct packed {
      logic signed [W-1:0] normal_x;
      logic signed [W-1:0] normal_y;
      logic signed [W-1:0] a_vel_x;
      logic signed [W-1:0] a_vel_y;
      logic signed [W-1:0] b_vel_x;
      logic signed [W-1:0] b_vel_y;
      logic [W-1:0]        a_inv_mass;
      logic [W-1:0]        b_inv_mass;
      logic                a_static;
      logic                b_static;
      logic [BW-1:0]       a_bounce;
      logic [BW-1:0]       b_bounce;
   } req_type;

   typedef struct packed {
      logic signed [W-1:0] a_new_vel_x;
      logic signed [W-1:0] a_new_vel_y;
      logic signed [W-1:0] b_new_vel_x;
      logic signed [W-1:0] b_new_vel_y;
      logic                impulse_applied;
      logic                set_grounded;
   } rsp_type;

   // Contact data that rides along the whole pipeline.
   typedef struct packed {
      logic signed [W-1:0] nx;
      logic signed [W-1:0] ny;
      logic signed [W-1:0] avx;
      logic signed [W-1:0] avy;
      logic signed [W-1:0] bvx;
      logic signed [W-1:0] bvy;
      logic [W-1:0]        ima;
      logic [W-1:0]        imb;
      logic                apply;
      logic                gnd;
   } ctx_type;

   function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] x);
      if (x > SAT_MAX) begin
         return SAT_MAX[W-1:0];
      end else if (x < SAT_MIN) begin
         return SAT_MIN[W-1:0];
      end
      return x[W-1:0];
   endfunction

   // Fixed-point rescale of a product: truncate toward zero, then saturate.
   function automatic logic signed [W-1:0] fix_sat(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] t;
      t = p + (p[PW-1] ? $signed(TRUNC_BIAS) : $signed(PW'(0)));
      t = t >>> F;
      return sat_w(t);
   endfunction

endpackage

@@ rtl/collision_impulse_resolve_top.sv @@
`timescale 1ns / 1ps
// Impulse resolution of one 2D contact between bodies A and B in signed fixed point.
// The req_ channel carries one contact per transaction: normal, both velocities,
// inverse masses, static flags and restitutions. The rsp_ channel returns one
// transaction per contact with the new velocities and the impulse and ground flags.
// Transactions leave in the order they arrived.
// The datapath is a linear pipeline of 43 register stages. One transaction is accepted
// every cycle while no result waits unread; the depth is set by the restoring divider,
// which resolves one quotient bit per stage, and by the two-step multiply and rescale
// around it.
// Each stage holds a valid bit next to its data. When the receiver holds rsp_ready
// low while a result waits, the whole pipeline freezes in place and req_ready
// drops; nothing is lost or repeated, and it resumes in the cycle ready returns.
// A synchronous reset clears every valid bit, leaving the pipeline empty; the data
// registers are not reset.
module collision_impulse_resolve_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cir_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cir_pkg::rsp_type rsp_data
);
   import cir_pkg::*;

   typedef struct packed {
      ctx_type             c;
      logic signed [W-1:0] rvx;
      logic signed [W-1:0] rvy;
      logic [DW-1:0]       den;
      logic [FCW-1:0]      factor;
   } s1_type;

   typedef struct packed {
      ctx_type               c;
      logic signed [2*W-1:0] px;
      logic signed [2*W-1:0] py;
      logic [DW-1:0]         den;
      logic [FCW-1:0]        factor;
   } s2_type;

   typedef struct packed {
      ctx_type             c;
      logic signed [W-1:0] fx;
      logic signed [W-1:0] fy;
      logic [DW-1:0]       den;
      logic [FCW-1:0]      factor;
   } s3_type;

   typedef struct packed {
      ctx_type        c;
      logic [DW-1:0]  negv;
      logic [DW-1:0]  den;
      logic [FCW-1:0] factor;
   } s4_type;

   typedef struct packed {
      ctx_type        c;
      logic [PRW-1:0] prod;
      logic [DW-1:0]  den;
   } s5_type;

   typedef struct packed {
      ctx_type       c;
      logic [W-2:0]  num;
      logic [DW-1:0] den;
   } s6_type;

   typedef struct packed {
      ctx_type       c;
      logic [RW-1:0] rem;
      logic [DW-1:0] den;
      logic [QB-1:0] quo;
      logic          sat;
   } div_type;

   typedef struct packed {
      ctx_type               c;
      logic signed [2*W-1:0] pix;
      logic signed [2*W-1:0] piy;
   } s8_type;

   typedef struct packed {
      ctx_type             c;
      logic signed [W-1:0] ix;
      logic signed [W-1:0] iy;
   } s9_type;

   typedef struct packed {
      ctx_type              c;
      logic signed [PW-1:0] pax;
      logic signed [PW-1:0] pay;
      logic signed [PW-1:0] pbx;
      logic signed [PW-1:0] pby;
   } s10_type;

   typedef struct packed {
      ctx_type             c;
      logic signed [W-1:0] dax;
      logic signed [W-1:0] day;
      logic signed [W-1:0] dbx;
      logic signed [W-1:0] dby;
   } s11_type;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   s6_type  s6_ff, s6_in;
   div_type div_ff [QB+1];
   div_type div_in [QB+1];
   s8_type  s8_ff, s8_in;
   s9_type  s9_ff, s9_in;
   s10_type s10_ff, s10_in;
   s11_type s11_ff, s11_in;
   rsp_type out_ff, out_in;

   logic [5:0]  head_v_ff;
   logic [QB:0] div_v_ff;
   logic [3:0]  tail_v_ff;
   logic        out_v_ff;
   logic        advance;

   // The pipeline moves as one; it only holds while a result waits unread.
   assign advance   = !out_v_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // Stage 1: relative velocity, inverse-mass sum and restitution factor.
   always_comb begin
      logic [BW-1:0] e_min;
      e_min = (req_data.a_bounce < req_data.b_bounce) ? req_data.a_bounce : req_data.b_bounce;
      s1_in.c.nx    = req_data.normal_x;
      s1_in.c.ny    = req_data.normal_y;
      s1_in.c.avx   = req_data.a_vel_x;
      s1_in.c.avy   = req_data.a_vel_y;
      s1_in.c.bvx   = req_data.b_vel_x;
      s1_in.c.bvy   = req_data.b_vel_y;
      s1_in.c.ima   = req_data.a_inv_mass;
      s1_in.c.imb   = req_data.b_inv_mass;
      s1_in.c.apply = !(req_data.a_static || req_data.b_static);
      s1_in.c.gnd   = (req_data.normal_y == $signed(NEG_ONE_Q));
      s1_in.rvx     = sat_w(PW'(req_data.b_vel_x) - PW'(req_data.a_vel_x));
      s1_in.rvy     = sat_w(PW'(req_data.b_vel_y) - PW'(req_data.a_vel_y));
      s1_in.den     = DW'(req_data.a_inv_mass) + DW'(req_data.b_inv_mass);
      s1_in.factor  = (FCW'(1) << F) + FCW'(e_min);
   end

   // Stage 2: normal-velocity products.
   always_comb begin
      s2_in.c      = s1_ff.c;
      s2_in.px     = s1_ff.rvx * s1_ff.c.nx;
      s2_in.py     = s1_ff.rvy * s1_ff.c.ny;
      s2_in.den    = s1_ff.den;
      s2_in.factor = s1_ff.factor;
   end

   // Stage 3: rescale both products.
   always_comb begin
      s3_in.c      = s2_ff.c;
      s3_in.fx     = fix_sat(PW'(s2_ff.px));
      s3_in.fy     = fix_sat(PW'(s2_ff.py));
      s3_in.den    = s2_ff.den;
      s3_in.factor = s2_ff.factor;
   end

   // Stage 4: closing speed along the normal and the impulse decision.
   always_comb begin
      logic signed [W-1:0]  vn;
      logic signed [DW-1:0] vn_x;
      vn   = sat_w(PW'(s3_ff.fx) + PW'(s3_ff.fy));
      vn_x = DW'(vn);
      s4_in.c       = s3_ff.c;
      s4_in.c.apply = s3_ff.c.apply && !(vn > 0) && (s3_ff.den != '0);
      s4_in.negv    = DW'(-vn_x);
      s4_in.den     = s3_ff.den;
      s4_in.factor  = s3_ff.factor;
   end

   // Stage 5: numerator product.
   always_comb begin
      s5_in.c    = s4_ff.c;
      s5_in.prod = PRW'(s4_ff.factor) * PRW'(s4_ff.negv);
      s5_in.den  = s4_ff.den;
   end

   // Stage 6: rescale and clamp the numerator, which is never negative.
   always_comb begin
      logic [PRW-1:0] shifted;
      shifted   = s5_ff.prod >> F;
      s6_in.c   = s5_ff.c;
      s6_in.num = (shifted > PRW'(WMAX_MAG)) ? WMAX_MAG : shifted[W-2:0];
      s6_in.den = s5_ff.den;
   end

   // Divider entry: a quotient that cannot fit the word saturates right away.
   // After it, restoring division resolves one quotient bit per stage from the top down.
   always_comb begin
      logic [RW-1:0] n_ext;
      logic [RW-1:0] d_ext;
      logic [RW-1:0] d_sh;
      n_ext = RW'(s6_ff.num) << F;
      d_ext = RW'(s6_ff.den);
      div_in[0].c   = s6_ff.c;
      div_in[0].rem = n_ext;
      div_in[0].den = s6_ff.den;
      div_in[0].quo = '0;
      div_in[0].sat = (n_ext >= (d_ext << QB));
      for (int i = 1; i <= QB; i++) begin
         div_in[i] = div_ff[i-1];
         d_sh = RW'(div_ff[i-1].den) << (QB - i);
         if (div_ff[i-1].rem >= d_sh) begin
            div_in[i].rem = div_ff[i-1].rem - d_sh;
            div_in[i].quo[QB-i] = 1'b1;
         end
      end
   end

   // Stage 8: impulse vector products.
   always_comb begin
      logic signed [W-1:0] j;
      j = div_ff[QB].sat ? $signed({1'b0, WMAX_MAG}) : $signed({1'b0, div_ff[QB].quo});
      s8_in.c   = div_ff[QB].c;
      s8_in.pix = s8_in.c.nx * j;
      s8_in.piy = s8_in.c.ny * j;
   end

   // Stage 9: rescale the impulse vector.
   always_comb begin
      s9_in.c  = s8_ff.c;
      s9_in.ix = fix_sat(PW'(s8_ff.pix));
      s9_in.iy = fix_sat(PW'(s8_ff.piy));
   end

   // Stage 10: per-body velocity changes, scaled by inverse mass.
   always_comb begin
      s10_in.c   = s9_ff.c;
      s10_in.pax = s9_ff.ix * $signed({1'b0, s9_ff.c.ima});
      s10_in.pay = s9_ff.iy * $signed({1'b0, s9_ff.c.ima});
      s10_in.pbx = s9_ff.ix * $signed({1'b0, s9_ff.c.imb});
      s10_in.pby = s9_ff.iy * $signed({1'b0, s9_ff.c.imb});
   end

   // Stage 11: rescale the velocity changes.
   always_comb begin
      s11_in.c   = s10_ff.c;
      s11_in.dax = fix_sat(s10_ff.pax);
      s11_in.day = fix_sat(s10_ff.pay);
      s11_in.dbx = fix_sat(s10_ff.pbx);
      s11_in.dby = fix_sat(s10_ff.pby);
   end

   // Output stage: apply the impulse or pass the velocities through.
   always_comb begin
      ctx_type c;
      c = s11_ff.c;
      if (c.apply) begin
         out_in.a_new_vel_x = sat_w(PW'(c.avx) - PW'(s11_ff.dax));
         out_in.a_new_vel_y = sat_w(PW'(c.avy) - PW'(s11_ff.day));
         out_in.b_new_vel_x = sat_w(PW'(c.bvx) + PW'(s11_ff.dbx));
         out_in.b_new_vel_y = sat_w(PW'(c.bvy) + PW'(s11_ff.dby));
      end else begin
         out_in.a_new_vel_x = c.avx;
         out_in.a_new_vel_y = c.avy;
         out_in.b_new_vel_x = c.bvx;
         out_in.b_new_vel_y = c.bvy;
      end
      out_in.impulse_applied = c.apply;
      out_in.set_grounded    = c.apply && c.gnd;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         for (int i = 0; i <= QB; i++) begin
            div_ff[i] <= div_in[i];
         end
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s11_ff <= s11_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= '0;
         div_v_ff  <= '0;
         tail_v_ff <= '0;
         out_v_ff  <= 1'b0;
      end else if (advance) begin
         head_v_ff <= {head_v_ff[4:0], req_valid};
         div_v_ff  <= {div_v_ff[QB-1:0], head_v_ff[5]};
         tail_v_ff <= {tail_v_ff[2:0], div_v_ff[QB]};
         out_v_ff  <= tail_v_ff[3];
      end
   end

endmodule

@@ bench/collision_impulse_resolve_checker.sv @@
`timescale 1ns / 1ps
module collision_impulse_resolve_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cir_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cir_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   import cir_pkg::*;

   typedef logic signed [127:0] wide_t;

   localparam wide_t WORD_MAX = (wide_t'(1) <<< (W - 1)) - 1;
   localparam wide_t WORD_MIN = -WORD_MAX - 1;
   localparam wide_t UNIT     = wide_t'(1) <<< F;

   rsp_type resolved_q[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic wide_t clamp_word(input wide_t v);
      if (v > WORD_MAX) begin
         return WORD_MAX;
      end else if (v < WORD_MIN) begin
         return WORD_MIN;
      end
      return v;
   endfunction

   // Exact product, rescaled with truncation toward zero, then clamped.
   function automatic wide_t qmul(input wide_t a, input wide_t b);
      wide_t p;
      wide_t t;
      p = a * b;
      if (p < 0) begin
         t = -((-p) >>> F);
      end else begin
         t = p >>> F;
      end
      return clamp_word(t);
   endfunction

   function automatic rsp_type resolve_contact(input req_type c);
      wide_t   nx, ny, avx, avy, bvx, bvy, ima, imb, ea, eb;
      wide_t   vn, den, num, j, ix, iy;
      rsp_type r;
      nx  = wide_t'(c.normal_x);
      ny  = wide_t'(c.normal_y);
      avx = wide_t'(c.a_vel_x);
      avy = wide_t'(c.a_vel_y);
      bvx = wide_t'(c.b_vel_x);
      bvy = wide_t'(c.b_vel_y);
      ima = wide_t'({96'b0, c.a_inv_mass});
      imb = wide_t'({96'b0, c.b_inv_mass});
      ea  = wide_t'({111'b0, c.a_bounce});
      eb  = wide_t'({111'b0, c.b_bounce});
      r.impulse_applied = 1'b0;
      r.set_grounded    = 1'b0;
      if (!c.a_static && !c.b_static) begin
         vn  = clamp_word(qmul(clamp_word(bvx - avx), nx) + qmul(clamp_word(bvy - avy), ny));
         den = ima + imb;
         if (vn <= 0 && den != 0) begin
            num = qmul(UNIT + ((ea < eb) ? ea : eb), -vn);
            j = (num <<< F) / den;
            if (j > WORD_MAX) begin
               j = WORD_MAX;
            end
            ix  = qmul(nx, j);
            iy  = qmul(ny, j);
            avx = clamp_word(avx - qmul(ix, ima));
            avy = clamp_word(avy - qmul(iy, ima));
            bvx = clamp_word(bvx + qmul(ix, imb));
            bvy = clamp_word(bvy + qmul(iy, imb));
            r.impulse_applied = 1'b1;
            r.set_grounded    = (ny == -UNIT);
         end
      end
      r.a_new_vel_x = avx[W-1:0];
      r.a_new_vel_y = avy[W-1:0];
      r.b_new_vel_x = bvx[W-1:0];
      r.b_new_vel_y = bvy[W-1:0];
      return r;
   endfunction

   task automatic report(input string field, input logic [W-1:0] got, input logic [W-1:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            resolved_q.push_back(resolve_contact(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (resolved_q.size() == 0) begin
               report("unexpected transaction", W'(rsp_data), '0);
            end else begin
               want = resolved_q.pop_front();
               if (rsp_data.a_new_vel_x !== want.a_new_vel_x)
                  report("a_new_vel_x", rsp_data.a_new_vel_x, want.a_new_vel_x);
               if (rsp_data.a_new_vel_y !== want.a_new_vel_y)
                  report("a_new_vel_y", rsp_data.a_new_vel_y, want.a_new_vel_y);
               if (rsp_data.b_new_vel_x !== want.b_new_vel_x)
                  report("b_new_vel_x", rsp_data.b_new_vel_x, want.b_new_vel_x);
               if (rsp_data.b_new_vel_y !== want.b_new_vel_y)
                  report("b_new_vel_y", rsp_data.b_new_vel_y, want.b_new_vel_y);
               if (rsp_data.impulse_applied !== want.impulse_applied)
                  report("impulse_applied", W'(rsp_data.impulse_applied),
                         W'(want.impulse_applied));
               if (rsp_data.set_grounded !== want.set_grounded)
                  report("set_grounded", W'(rsp_data.set_grounded), W'(want.set_grounded));
            end
         end
         pending_count = resolved_q.size();
      end
   end

endmodule

@@ bench/collision_impulse_resolve_top_tb.sv @@
`timescale 1ns / 1ps
module collision_impulse_resolve_top_tb;
   import cir_pkg::*;

   // Total number of random contacts after the directed part.
   localparam int RANDOM_ITEMS = 2000;
   // Pipeline depth of the block plus some margin for the drain at the end.
   localparam int DRAIN_CYCLES = 80;
   // Length of the one long receiver hold-off that fills the pipeline.
   localparam int LONG_HOLD = 300;
   // Restitution of exactly one in the bounce field width.
   localparam logic [BW-1:0] BOUNCE_ONE = BW'(ONE_Q);

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   // Number of request transactions accepted so far; the receiver uses it to
   // time its long hold-off.
   int sent_count;
   bit long_hold_done;

   collision_impulse_resolve_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   collision_impulse_resolve_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Builds one contact from its fields; both bodies are dynamic unless the
   // caller sets a static flag afterwards.
   function automatic req_type contact(input logic [W-1:0] nx, input logic [W-1:0] ny,
                                       input logic [W-1:0] avx, input logic [W-1:0] avy,
                                       input logic [W-1:0] bvx, input logic [W-1:0] bvy,
                                       input logic [W-1:0] ima, input logic [W-1:0] imb,
                                       input logic [BW-1:0] ea, input logic [BW-1:0] eb);
      req_type c;
      c.normal_x   = nx;
      c.normal_y   = ny;
      c.a_vel_x    = avx;
      c.a_vel_y    = avy;
      c.b_vel_x    = bvx;
      c.b_vel_y    = bvy;
      c.a_inv_mass = ima;
      c.b_inv_mass = imb;
      c.a_static   = 1'b0;
      c.b_static   = 1'b0;
      c.a_bounce   = ea;
      c.b_bounce   = eb;
      return c;
   endfunction

   // A signed value spread evenly over [-span, span].
   function automatic logic [W-1:0] spread(input int unsigned span);
      return W'($urandom_range(0, 2 * span)) - W'(span);
   endfunction

   // Most random contacts look like what a solver produces: normal components
   // within [-1, 1], moderate velocities and masses, mostly dynamic bodies. The
   // rest are raw noise over every bit of every field.
   function automatic req_type random_contact();
      req_type c;
      int unsigned shape;
      shape = $urandom_range(0, 9);
      if (shape < 7) begin
         c = contact(spread(ONE_Q), spread(ONE_Q), spread(1 << 20), spread(1 << 20),
                     spread(1 << 20), spread(1 << 20), $urandom_range(0, 4 * ONE_Q),
                     $urandom_range(0, 4 * ONE_Q), BW'($urandom_range(0, ONE_Q)),
                     BW'($urandom_range(0, ONE_Q)));
         // Floor contacts exercise the grounding flag.
         if ($urandom_range(0, 3) == 0) begin
            c.normal_x = '0;
            c.normal_y = NEG_ONE_Q;
         end
         c.a_static = ($urandom_range(0, 15) == 0);
         c.b_static = ($urandom_range(0, 15) == 0);
      end else begin
         c = contact($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, BW'($urandom), BW'($urandom));
         c.a_static = 1'($urandom);
         c.b_static = 1'($urandom);
      end
      return c;
   endfunction

   // Offers one contact after the given gap and holds it until it is taken.
   // With a zero gap valid stays high from the previous transaction.
   task automatic send_contact(input req_type c, input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (!req_ready);
      sent_count = sent_count + 1;
   endtask

   // Receiver: a random pause before each result, plus one long hold-off
   // while the sender keeps pushing, so the pipeline fills and req_ready drops.
   initial begin
      int unsigned pause;
      rsp_ready = 1'b0;
      long_hold_done = 1'b0;
      @(negedge reset);
      forever begin
         if (!long_hold_done && sent_count >= 600) begin
            pause = LONG_HOLD;
            long_hold_done = 1'b1;
         end else begin
            pause = $urandom_range(0, 10);
         end
         repeat (pause) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Hard limit on the run, well beyond the slowest correct case.
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      req_type   c;
      int        i;
      int unsigned gap;
      req_valid  = 1'b0;
      req_data   = '0;
      sent_count = 0;
      reset      = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed contacts. A head-on hit along x with equal masses.
      send_contact(contact(ONE_Q, '0, ONE_Q, '0, -ONE_Q, '0, ONE_Q, ONE_Q, '0, '0), 0);
      // Bodies moving apart along a floor normal, full restitution: no impulse, no grounding.
      send_contact(contact('0, NEG_ONE_Q, '0, ONE_Q, '0, -ONE_Q, ONE_Q, ONE_Q,
                           BOUNCE_ONE, BOUNCE_ONE), 0);
      // Same contact but body A static, then body B static, then both.
      c = contact('0, NEG_ONE_Q, '0, ONE_Q, '0, -ONE_Q, ONE_Q, ONE_Q, BOUNCE_ONE,
                  BOUNCE_ONE);
      c.a_static = 1'b1;
      send_contact(c, 0);
      c.a_static = 1'b0;
      c.b_static = 1'b1;
      send_contact(c, 1);
      c.a_static = 1'b1;
      send_contact(c, 0);
      // Separating bodies pass through.
      send_contact(contact(ONE_Q, '0, -ONE_Q, '0, ONE_Q, '0, ONE_Q, ONE_Q, '0, '0), 0);
      // Relative normal velocity exactly zero still counts as touching.
      send_contact(contact(ONE_Q, '0, ONE_Q, ONE_Q, ONE_Q, '0, ONE_Q, ONE_Q, '0, '0), 2);
      // Both inverse masses zero: no impulse.
      send_contact(contact(ONE_Q, '0, ONE_Q, '0, -ONE_Q, '0, '0, '0, BOUNCE_ONE,
                           BOUNCE_ONE), 0);
      // Restitution above one on both bodies is used as given; then body B has the smaller one.
      send_contact(contact(ONE_Q, '0, ONE_Q, '0, -ONE_Q, '0, ONE_Q, ONE_Q,
                           17'h1FFFF, 17'h1FFFF), 0);
      send_contact(contact(ONE_Q, '0, ONE_Q, '0, -ONE_Q, '0, ONE_Q, ONE_Q,
                           17'h1FFFF, 17'h08000), 0);
      // Extreme velocities and masses that drive the arithmetic into saturation.
      send_contact(contact(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           BOUNCE_ONE, BOUNCE_ONE), 0);
      send_contact(contact(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, '0, '0, BOUNCE_ONE), 3);
      send_contact(contact(32'h80000000, '0, 32'h7FFFFFFF, '0, 32'h80000000, '0,
                           32'h00000001, 32'h00000001, BOUNCE_ONE, BOUNCE_ONE), 0);
      // Tiny inverse mass on one side only: a huge impulse scalar.
      send_contact(contact(ONE_Q, '0, ONE_Q, '0, -ONE_Q, '0, 32'h00000001, '0,
                           '0, '0), 0);
      // Floor normal with approaching bodies: grounding.
      send_contact(contact('0, NEG_ONE_Q, '0, -ONE_Q, '0, ONE_Q, ONE_Q, ONE_Q, '0, '0), 0);
      // Normal y just off minus one: no grounding flag.
      send_contact(contact('0, NEG_ONE_Q + 1, '0, ONE_Q, '0, -ONE_Q, ONE_Q, ONE_Q,
                           '0, '0), 0);
      // All fields zero and all ones.
      send_contact('0, 0);
      send_contact('1, 0);

      // Random contacts. Every third block of 200 runs back to back.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         gap = ((i / 200) % 3 == 0) ? 0 : $urandom_range(0, 10);
         send_contact(random_contact(), gap);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain: wait for every outstanding result, then a little longer so a
      // stray extra transaction would still be caught.
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
